@@ hdl/bpslc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bpslc_pkg;

    localparam int TIMER_W    = 16;
    localparam int PRESS_W    = 3;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic [PRESS_W-1:0] PRESS_MAX = '1;

    typedef enum logic [2:0] {
        REG_DEBOUNCE     = 3'd0,
        REG_LONG_PRESS   = 3'd1,
        REG_DOUBLE_PRESS = 3'd2,
        REG_THROB_PERIOD = 3'd3,
        REG_AMBIENT_RED  = 3'd4,
        REG_AMBIENT_GRN  = 3'd5,
        REG_AMBIENT_BLU  = 3'd6,
        REG_BTN_OVERRIDE = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        COL_OFF   = 2'd0,
        COL_RED   = 2'd1,
        COL_GREEN = 2'd2,
        COL_BLUE  = 2'd3
    } t_colour;

    typedef enum logic [1:0] {
        UNLOAD_NONE = 2'd0,
        UNLOAD_E    = 2'd1,
        UNLOAD_D    = 2'd2
    } t_unload;

    localparam logic [15:0] RST_DEBOUNCE     = 16'd30;
    localparam logic [15:0] RST_LONG_PRESS   = 16'd800;
    localparam logic [15:0] RST_DOUBLE_PRESS = 16'd300;
    localparam logic [15:0] RST_THROB_PERIOD = 16'd1000;
    localparam logic [7:0]  RST_AMBIENT_RED  = 8'hff;
    localparam logic [7:0]  RST_AMBIENT_GRN  = 8'hd7;
    localparam logic [7:0]  RST_AMBIENT_BLU  = 8'h64;
    localparam logic [7:0]  LED_FULL         = 8'hff;

    typedef struct packed {
        logic [15:0] debounce_ticks;
        logic [15:0] long_press_ticks;
        logic [15:0] double_press_ticks;
        logic [15:0] throb_period_ticks;
        logic [7:0]  ambient_red;
        logic [7:0]  ambient_green;
        logic [7:0]  ambient_blue;
        logic        button_led_override;
    } t_cfg;

    typedef struct packed {
        logic button_level;
        logic job_running;
        logic paused;
        logic user_paused;
        logic error_present;
        logic unloading_e;
        logic unloading_d;
        logic head_power_on;
        logic reel0_present;
        logic reel1_present;
        logic head_dual_material;
    } t_in_item;

    typedef struct packed {
        logic       clear_errors;
        logic       toggle_pause;
        logic       start_last_job;
        logic [1:0] unload_request;
        logic [7:0] ambient_r;
        logic [7:0] ambient_g;
        logic [7:0] ambient_b;
        logic [1:0] button_colour;
        logic       button_instant;
        logic       button_drive;
    } t_out_item;

    typedef struct packed {
        logic    clear_errors;
        logic    toggle_pause;
        logic    start_last_job;
        t_unload unload_request;
    } t_press_evt;

    typedef struct packed {
        logic level;
        logic prev_level;
    } t_btn_status;

    typedef struct packed {
        logic [7:0] ambient_r;
        logic [7:0] ambient_g;
        logic [7:0] ambient_b;
        t_colour    button_colour;
        logic       button_instant;
        logic       button_drive;
    } t_led_out;

endpackage

`default_nettype wire

@@ hdl/bpslc_ifs.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface bpslc_in_if;
    logic                valid;
    logic                ready;
    bpslc_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bpslc_out_if;
    logic                 valid;
    logic                 ready;
    bpslc_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/bpslc_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bpslc_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bpslc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [bpslc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [bpslc_pkg::APB_DATA_W-1:0] prdata,
    output logic                             pready,
    output bpslc_pkg::t_cfg                  o_cfg
);
    import bpslc_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks      <= RST_DEBOUNCE;
            r_cfg.long_press_ticks    <= RST_LONG_PRESS;
            r_cfg.double_press_ticks  <= RST_DOUBLE_PRESS;
            r_cfg.throb_period_ticks  <= RST_THROB_PERIOD;
            r_cfg.ambient_red         <= RST_AMBIENT_RED;
            r_cfg.ambient_green       <= RST_AMBIENT_GRN;
            r_cfg.ambient_blue        <= RST_AMBIENT_BLU;
            r_cfg.button_led_override <= 1'b0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_DEBOUNCE:     r_cfg.debounce_ticks      <= pwdata[15:0];
                REG_LONG_PRESS:   r_cfg.long_press_ticks    <= pwdata[15:0];
                REG_DOUBLE_PRESS: r_cfg.double_press_ticks  <= pwdata[15:0];
                REG_THROB_PERIOD: r_cfg.throb_period_ticks  <= pwdata[15:0];
                REG_AMBIENT_RED:  r_cfg.ambient_red         <= pwdata[7:0];
                REG_AMBIENT_GRN:  r_cfg.ambient_green       <= pwdata[7:0];
                REG_AMBIENT_BLU:  r_cfg.ambient_blue        <= pwdata[7:0];
                REG_BTN_OVERRIDE: r_cfg.button_led_override <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_DEBOUNCE:     prdata = APB_DATA_W'(r_cfg.debounce_ticks);
            REG_LONG_PRESS:   prdata = APB_DATA_W'(r_cfg.long_press_ticks);
            REG_DOUBLE_PRESS: prdata = APB_DATA_W'(r_cfg.double_press_ticks);
            REG_THROB_PERIOD: prdata = APB_DATA_W'(r_cfg.throb_period_ticks);
            REG_AMBIENT_RED:  prdata = APB_DATA_W'(r_cfg.ambient_red);
            REG_AMBIENT_GRN:  prdata = APB_DATA_W'(r_cfg.ambient_green);
            REG_AMBIENT_BLU:  prdata = APB_DATA_W'(r_cfg.ambient_blue);
            REG_BTN_OVERRIDE: prdata = APB_DATA_W'(r_cfg.button_led_override);
            default:          prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/bpslc_press.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bpslc_press (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  bpslc_pkg::t_cfg        i_cfg,
    input  bpslc_pkg::t_in_item    i_item,
    output bpslc_pkg::t_press_evt  o_evt,
    output bpslc_pkg::t_btn_status o_btn
);
    import bpslc_pkg::*;

    logic [TIMER_W-1:0] r_stable, n_stable;
    logic               r_prev;
    logic [PRESS_W-1:0] r_count, n_count;
    logic               r_released, n_released;

    logic [TIMER_W-1:0] stable_now;
    logic               unloading;
    logic               can_start;
    logic               debounced;

    assign o_btn.level      = i_item.button_level;
    assign o_btn.prev_level = r_prev;

    always_comb begin
        // an edge restarts the stability count before it is judged
        stable_now = (i_item.button_level != r_prev) ? '0 : r_stable;
        unloading  = i_item.unloading_e || i_item.unloading_d;
        can_start  = i_item.head_power_on && !unloading && i_item.reel0_present
                     && (i_item.reel1_present || !i_item.head_dual_material);
        debounced  = 32'(stable_now) >= 32'(i_cfg.debounce_ticks);

        n_count    = r_count;
        n_released = r_released;
        o_evt.clear_errors   = 1'b0;
        o_evt.toggle_pause   = 1'b0;
        o_evt.start_last_job = 1'b0;
        o_evt.unload_request = UNLOAD_NONE;

        if (debounced) begin
            if (i_item.button_level) begin
                if (i_item.job_running) begin
                    if (r_count != '0) begin
                        o_evt.clear_errors = i_item.paused;
                        o_evt.toggle_pause = 1'b1;
                        n_count            = '0;
                    end
                end else if (r_count > PRESS_W'(1)) begin
                    o_evt.start_last_job = can_start;
                    n_count              = '0;
                end
                if (32'(stable_now) >= 32'(i_cfg.double_press_ticks)) begin
                    n_count = '0;
                end
                n_released = 1'b1;
            end else begin
                if (32'(stable_now) < 32'(i_cfg.long_press_ticks)) begin
                    if (r_released && r_count != PRESS_MAX) begin
                        n_count = r_count + PRESS_W'(1);
                    end
                    n_released = 1'b0;
                end else if (r_count != '0) begin
                    if (!unloading) begin
                        o_evt.unload_request = i_item.reel1_present ? UNLOAD_D : UNLOAD_E;
                    end
                    n_count = '0;
                end
            end
        end

        n_stable = (stable_now == '1) ? stable_now : stable_now + TIMER_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable   <= '0;
            r_prev     <= 1'b0;
            r_count    <= '0;
            r_released <= 1'b0;
        end else if (i_step) begin
            r_stable   <= n_stable;
            r_prev     <= i_item.button_level;
            r_count    <= n_count;
            r_released <= n_released;
        end
    end

    a_clear_with_toggle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_evt.clear_errors |-> o_evt.toggle_pause)
        else $error("clear_errors without toggle_pause");

    a_toggle_not_unload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_evt.toggle_pause |-> o_evt.unload_request == UNLOAD_NONE)
        else $error("toggle and unload in one beat");

    a_start_not_toggle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_evt.start_last_job |-> !o_evt.toggle_pause)
        else $error("start and toggle in one beat");

    a_prev_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |=> r_prev == $past(i_item.button_level))
        else $error("previous level not taken from last beat");

endmodule

`default_nettype wire

@@ hdl/bpslc_led.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bpslc_led (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  bpslc_pkg::t_cfg        i_cfg,
    input  bpslc_pkg::t_in_item    i_item,
    input  bpslc_pkg::t_btn_status i_btn,
    output bpslc_pkg::t_led_out    o_led
);
    import bpslc_pkg::*;

    logic [TIMER_W-1:0] r_throb, n_throb;
    logic               r_flip;

    logic               half_elapsed;
    logic               period_done;
    logic               unloading;
    logic [TIMER_W-1:0] throb_base;

    always_comb begin
        half_elapsed = 32'(r_throb) >= 32'(i_cfg.throb_period_ticks >> 1);
        period_done  = 32'(r_throb) >= 32'(i_cfg.throb_period_ticks);
        unloading    = i_item.unloading_e || i_item.unloading_d;

        if (!i_item.user_paused || (half_elapsed && r_flip)) begin
            o_led.ambient_r = i_cfg.ambient_red;
            o_led.ambient_g = i_cfg.ambient_green;
            o_led.ambient_b = i_cfg.ambient_blue;
        end else if (!half_elapsed) begin
            o_led.ambient_r = '0;
            o_led.ambient_g = '0;
            o_led.ambient_b = '0;
        end else if (i_item.error_present) begin
            o_led.ambient_r = LED_FULL;
            o_led.ambient_g = '0;
            o_led.ambient_b = '0;
        end else begin
            o_led.ambient_r = '0;
            o_led.ambient_g = LED_FULL;
            o_led.ambient_b = '0;
        end

        o_led.button_colour  = COL_OFF;
        o_led.button_instant = 1'b0;
        o_led.button_drive   = 1'b0;
        if (!i_cfg.button_led_override) begin
            o_led.button_drive = 1'b1;
            if (unloading) begin
                o_led.button_colour = half_elapsed ? COL_BLUE : COL_OFF;
            end else if (!i_btn.level) begin
                o_led.button_colour  = COL_BLUE;
                o_led.button_instant = 1'b1;
            end else if (!i_btn.prev_level) begin
                // just released: snap off
                o_led.button_instant = 1'b1;
            end else if (i_item.job_running && i_item.error_present) begin
                o_led.button_colour = (!i_item.paused || half_elapsed) ? COL_RED : COL_OFF;
            end else if (i_item.job_running) begin
                o_led.button_colour = (!i_item.user_paused || half_elapsed)
                                      ? COL_GREEN : COL_OFF;
            end
        end

        throb_base = period_done ? '0 : r_throb;
        n_throb    = (throb_base == '1) ? throb_base : throb_base + TIMER_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_throb <= '0;
            r_flip  <= 1'b0;
        end else if (i_step) begin
            r_throb <= n_throb;
            r_flip  <= r_flip ^ period_done;
        end
    end

    a_override_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg.button_led_override |-> !o_led.button_drive && !o_led.button_instant
                                      && o_led.button_colour == COL_OFF)
        else $error("button LED driven while overridden");

    a_flip_on_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && period_done |=> r_throb == TIMER_W'(1) && r_flip != $past(r_flip))
        else $error("throb restart not taken");

    a_flip_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_step && period_done) |=> $stable(r_flip))
        else $error("flip changed without a restart");

endmodule

`default_nettype wire

@@ hdl/button_press_and_status_led_controller_top.sv @@
// Button and status LED controller. Each input beat is one tick: the sampled
// active-low button level plus the printer status flags. Each beat yields
// exactly one result beat with the press events (clear errors, toggle pause,
// start last job, unload request) and the ambient and button LED settings.
// One beat is accepted per clock while the result side keeps up. A beat is
// held in the input register, and its result goes into the result register
// once that is empty or being read. The input register lets one more beat
// enter while an unread result waits. Timing, colour and override registers
// sit on an APB port at byte address 4*index. The user must write them only
// while the block is idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module button_press_and_status_led_controller_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bpslc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [bpslc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [bpslc_pkg::APB_DATA_W-1:0] prdata,
    output logic                             pready,
    bpslc_in_if.sink                         i_in,
    bpslc_out_if.source                      o_out
);
    import bpslc_pkg::*;

    t_cfg        cfg;
    t_in_item    r_in;
    logic        r_in_vld;
    t_out_item   r_out;
    logic        r_out_vld;
    logic        advance;
    logic        in_accept;
    t_press_evt  evt;
    t_btn_status btn;
    t_led_out    led;

    bpslc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign advance    = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || advance;
    assign in_accept  = i_in.valid && i_in.ready;

    bpslc_press u_press (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_cfg   (cfg),
        .i_item  (r_in),
        .o_evt   (evt),
        .o_btn   (btn)
    );

    bpslc_led u_led (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_cfg   (cfg),
        .i_item  (r_in),
        .i_btn   (btn),
        .o_led   (led)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in.data;
        end
        if (advance) begin
            r_out.clear_errors   <= evt.clear_errors;
            r_out.toggle_pause   <= evt.toggle_pause;
            r_out.start_last_job <= evt.start_last_job;
            r_out.unload_request <= evt.unload_request;
            r_out.ambient_r      <= led.ambient_r;
            r_out.ambient_g      <= led.ambient_g;
            r_out.ambient_b      <= led.ambient_b;
            r_out.button_colour  <= led.button_colour;
            r_out.button_instant <= led.button_instant;
            r_out.button_drive   <= led.button_drive;
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !o_out.ready |-> !advance)
        else $error("pending result overwritten");

    a_in_not_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !advance |-> !in_accept)
        else $error("held beat overwritten");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_vld)
        else $error("processed beat gave no result");

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import bpslc_pkg::*;

    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 6;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    bpslc_in_if  in_if ();
    bpslc_out_if out_if ();

    button_press_and_status_led_controller_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #6 i_clk = ~i_clk;

    // shadow of the register file, starts at the reset values
    t_cfg cfg_now = '{RST_DEBOUNCE, RST_LONG_PRESS, RST_DOUBLE_PRESS, RST_THROB_PERIOD,
                      RST_AMBIENT_RED, RST_AMBIENT_GRN, RST_AMBIENT_BLU, 1'b0};

    // button and throb state as the block should hold it
    logic [TIMER_W-1:0] btn_stable      = '0;
    logic [TIMER_W-1:0] throb_count     = '0;
    logic               last_level      = 1'b0;
    logic [PRESS_W-1:0] pending_presses = '0;
    logic               seen_release    = 1'b0;
    logic               throb_flip      = 1'b0;

    t_out_item expected_ticks[$];

    int  mismatch_count = 0;
    int  result_index   = 0;
    int  tick_count     = 0;
    int  quiet_cycles   = 0;
    int  hold_left      = 0;
    int  stall_left     = 0;
    bit  tx_idle_en     = 1'b1;
    bit  rx_idle_en     = 1'b1;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_out_item predict_tick(input t_in_item t);
        t_out_item r;
        logic      unloading;
        logic      half;
        r = '0;
        unloading = t.unloading_e | t.unloading_d;
        if (t.button_level != last_level)
            btn_stable = '0;

        if (btn_stable >= cfg_now.debounce_ticks) begin
            if (t.button_level) begin
                if (t.job_running) begin
                    if (pending_presses != 0) begin
                        r.clear_errors = t.paused;
                        r.toggle_pause = 1'b1;
                        pending_presses = '0;
                    end
                end else if (pending_presses > 1) begin
                    r.start_last_job = t.head_power_on && !unloading && t.reel0_present &&
                                       (t.reel1_present || !t.head_dual_material);
                    pending_presses = '0;
                end
                if (btn_stable >= cfg_now.double_press_ticks)
                    pending_presses = '0;
                seen_release = 1'b1;
            end else begin
                if (btn_stable < cfg_now.long_press_ticks) begin
                    if (seen_release && pending_presses != PRESS_MAX)
                        pending_presses++;
                    seen_release = 1'b0;
                end else if (pending_presses != 0) begin
                    if (!unloading)
                        r.unload_request = t.reel1_present ? UNLOAD_D : UNLOAD_E;
                    pending_presses = '0;
                end
            end
        end

        half = throb_count >= (cfg_now.throb_period_ticks >> 1);

        if (!t.user_paused || (half && throb_flip)) begin
            r.ambient_r = cfg_now.ambient_red;
            r.ambient_g = cfg_now.ambient_green;
            r.ambient_b = cfg_now.ambient_blue;
        end else if (!half) begin
            r.ambient_r = '0;
            r.ambient_g = '0;
            r.ambient_b = '0;
        end else if (t.error_present) begin
            r.ambient_r = LED_FULL;
        end else begin
            r.ambient_g = LED_FULL;
        end

        if (!cfg_now.button_led_override) begin
            r.button_drive = 1'b1;
            if (unloading) begin
                r.button_colour = half ? COL_BLUE : COL_OFF;
            end else if (!t.button_level) begin
                r.button_colour  = COL_BLUE;
                r.button_instant = 1'b1;
            end else if (!last_level) begin
                r.button_colour  = COL_OFF;
                r.button_instant = 1'b1;
            end else if (t.job_running && t.error_present) begin
                r.button_colour = (!t.paused || half) ? COL_RED : COL_OFF;
            end else if (t.job_running) begin
                r.button_colour = (!t.user_paused || half) ? COL_GREEN : COL_OFF;
            end
        end

        if (throb_count >= cfg_now.throb_period_ticks) begin
            throb_count = '0;
            throb_flip  = ~throb_flip;
        end
        if (throb_count != '1) throb_count++;
        if (btn_stable != '1) btn_stable++;
        last_level = t.button_level;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: %s mismatch at result %0d: expected %0h, got %0h",
                         $time, name, result_index, want, got);
        end
    endtask

    // result beats against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        t_out_item got;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = out_if.data;
            if (expected_ticks.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result beat with nothing expected: %0h", $time, got);
            end else begin
                want = expected_ticks.pop_front();
                check_field("clear_errors", want.clear_errors, got.clear_errors);
                check_field("toggle_pause", want.toggle_pause, got.toggle_pause);
                check_field("start_last_job", want.start_last_job, got.start_last_job);
                check_field("unload_request", want.unload_request, got.unload_request);
                check_field("ambient_r", want.ambient_r, got.ambient_r);
                check_field("ambient_g", want.ambient_g, got.ambient_g);
                check_field("ambient_b", want.ambient_b, got.ambient_b);
                check_field("button_colour", want.button_colour, got.button_colour);
                check_field("button_instant", want.button_instant, got.button_instant);
                check_field("button_drive", want.button_drive, got.button_drive);
            end
            result_index++;
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
            $display("** button_press_and_status_led_controller_top: FAILED **");
            $finish;
        end
    end

    // result side: long hold-off when asked, otherwise random stalls if enabled
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready = 1'b0;
        end else if (hold_left > 0) begin
            out_if.ready = 1'b0;
            hold_left--;
        end else if (stall_left > 0) begin
            out_if.ready = 1'b0;
            stall_left--;
        end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
            out_if.ready = (stall_left == 0);
            if (stall_left > 0) stall_left--;
        end else begin
            out_if.ready = 1'b1;
        end
    end

    task automatic send_tick(input t_in_item item);
        int gap;
        @(negedge i_clk);
        in_if.valid = 1'b1;
        in_if.data  = item;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        expected_ticks.push_back(predict_tick(item));
        tick_count++;
        gap = tx_idle_en ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            in_if.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic hold_level(input logic lvl, input int n, input t_in_item flags,
                              input bit noisy);
        t_in_item item;
        for (int k = 0; k < n; k++) begin
            item = flags;
            item.button_level = lvl;
            // odd status flag flipping mid-press
            if (noisy && $urandom_range(0, 19) == 0)
                item = t_in_item'(item ^ (11'd1 << $urandom_range(0, 9)));
            send_tick(item);
        end
    endtask

    task automatic drain_outputs();
        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (expected_ticks.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        logic [31:0] mask;
        logic [31:0] readback;
        case (idx)
            REG_DEBOUNCE: begin
                cfg_now.debounce_ticks = value[15:0];
                mask = 32'hffff;
            end
            REG_LONG_PRESS: begin
                cfg_now.long_press_ticks = value[15:0];
                mask = 32'hffff;
            end
            REG_DOUBLE_PRESS: begin
                cfg_now.double_press_ticks = value[15:0];
                mask = 32'hffff;
            end
            REG_THROB_PERIOD: begin
                cfg_now.throb_period_ticks = value[15:0];
                mask = 32'hffff;
            end
            REG_AMBIENT_RED: begin
                cfg_now.ambient_red = value[7:0];
                mask = 32'hff;
            end
            REG_AMBIENT_GRN: begin
                cfg_now.ambient_green = value[7:0];
                mask = 32'hff;
            end
            REG_AMBIENT_BLU: begin
                cfg_now.ambient_blue = value[7:0];
                mask = 32'hff;
            end
            default: begin
                cfg_now.button_led_override = value[0];
                mask = 32'h1;
            end
        endcase
        @(negedge i_clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
        psel = 1'b1;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        readback = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        check_field({"readback of ", idx.name()}, value & mask, readback);
    endtask

    task automatic load_config(input int deb, input int lng, input int dbl, input int throb,
                               input int red, input int grn, input int blu,
                               input bit ovr);
        drain_outputs();
        write_reg(REG_DEBOUNCE, deb);
        write_reg(REG_LONG_PRESS, lng);
        write_reg(REG_DOUBLE_PRESS, dbl);
        write_reg(REG_THROB_PERIOD, throb);
        write_reg(REG_AMBIENT_RED, red);
        write_reg(REG_AMBIENT_GRN, grn);
        write_reg(REG_AMBIENT_BLU, blu);
        write_reg(REG_BTN_OVERRIDE, ovr);
    endtask

    function automatic int rand_level8();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 0;
        if (r == 1) return 255;
        return $urandom_range(0, 255);
    endfunction

    function automatic t_in_item rand_flags();
        t_in_item f;
        f = t_in_item'(11'($urandom));
        f.head_power_on = ($urandom_range(0, 4) != 0);
        f.reel0_present = ($urandom_range(0, 4) != 0);
        f.unloading_e   = ($urandom_range(0, 5) == 0);
        f.unloading_d   = ($urandom_range(0, 5) == 0);
        return f;
    endfunction

    // press sequences sized to the current timing, with some glitches and noise
    task automatic run_sessions(input int n_items);
        int       stop_at;
        int       deb;
        int       lng;
        int       dbl;
        t_in_item f;
        stop_at = tick_count + n_items;
        deb = (cfg_now.debounce_ticks > 30) ? 30 : int'(cfg_now.debounce_ticks);
        lng = (cfg_now.long_press_ticks > 40) ? 40 : int'(cfg_now.long_press_ticks);
        dbl = (cfg_now.double_press_ticks > 40) ? 40 : int'(cfg_now.double_press_ticks);
        while (tick_count < stop_at) begin
            f = rand_flags();
            case ($urandom_range(0, 9))
                0, 1, 2: hold_level(1'b0, $urandom_range(deb + 1, lng), f, 1'b1);
                3, 4, 5: begin
                    hold_level(1'b0, $urandom_range(deb + 1, lng), f, 1'b1);
                    hold_level(1'b1, $urandom_range(deb + 1, dbl), f, 1'b1);
                    hold_level(1'b0, $urandom_range(deb + 1, lng), f, 1'b1);
                end
                6, 7: hold_level(1'b0, $urandom_range(lng + 1, lng + 4), f, 1'b1);
                8: begin
                    for (int k = 0; k < 2 * deb + 2; k++)
                        hold_level(k[0], $urandom_range(1, deb), f, 1'b1);
                end
                default: begin
                    repeat ($urandom_range(1, 6)) send_tick(t_in_item'(11'($urandom)));
                end
            endcase
            hold_level(1'b1, $urandom_range(deb + 1, dbl + 5), f, 1'b1);
        end
    endtask

    task automatic test_reset_values();
        t_in_item f;
        f = rand_flags();
        f.user_paused = 1'b0;
        hold_level(1'b1, 3, f, 1'b0);
    endtask

    task automatic test_press_events();
        t_in_item f;
        load_config(1, 3, 2, 2, 8'h80, 8'h40, 8'h20, 1'b0);
        f = '0;
        f.job_running   = 1'b1;
        f.head_power_on = 1'b1;
        f.reel0_present = 1'b1;
        f.reel1_present = 1'b1;
        // short press while running and paused: clear errors and toggle
        hold_level(1'b1, 2, f, 1'b0);
        hold_level(1'b0, 2, f, 1'b0);
        f.paused = 1'b1;
        hold_level(1'b1, 2, f, 1'b0);
        // double press while idle starts the last job
        f.job_running = 1'b0;
        f.paused      = 1'b0;
        hold_level(1'b0, 2, f, 1'b0);
        hold_level(1'b1, 2, f, 1'b0);
        hold_level(1'b0, 2, f, 1'b0);
        hold_level(1'b1, 2, f, 1'b0);
        // long press with reel 1 fitted unloads D
        hold_level(1'b0, 4, f, 1'b0);
    endtask

    task automatic test_led_throb();
        t_in_item f;
        load_config(1, 3, 2, 3, 8'h12, 8'h34, 8'h56, 1'b0);
        f = '0;
        f.job_running   = 1'b1;
        f.paused        = 1'b1;
        f.user_paused   = 1'b1;
        f.error_present = 1'b1;
        hold_level(1'b1, 3, f, 1'b0);
        f.error_present = 1'b0;
        f.unloading_e   = 1'b1;
        hold_level(1'b1, 2, f, 1'b0);
        drain_outputs();
        write_reg(REG_BTN_OVERRIDE, 1);
        hold_level(1'b0, 2, f, 1'b0);
    endtask

    task automatic test_config_extremes();
        load_config(1, 1, 1, 2, 0, 0, 0, 1'b0);
        run_sessions(70);
        load_config(65535, 65535, 65535, 65535, 255, 255, 255, 1'b1);
        run_sessions(40);
    endtask

    task automatic test_random_sessions();
        int deb;
        for (int p = 0; p < 7; p++) begin
            deb = $urandom_range(1, 4);
            load_config(deb, deb + $urandom_range(3, 20), deb + $urandom_range(2, 15),
                        $urandom_range(2, 24), rand_level8(), rand_level8(), rand_level8(),
                        $urandom_range(0, 4) == 0);
            // first phase runs flat out on both sides
            tx_idle_en = (p != 0);
            rx_idle_en = (p != 0) && (p != 3);
            run_sessions(160);
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    task automatic test_backpressure();
        load_config(2, 12, 8, 9, rand_level8(), rand_level8(), rand_level8(), 1'b0);
        hold_left  = 300;
        tx_idle_en = 1'b0;
        run_sessions(60);
        tx_idle_en = 1'b1;
    endtask

    // long steady press with the widest press windows while the throb wraps
    task automatic test_timer_saturation();
        t_in_item f;
        load_config(2, 65535, 65535, 40, 8'h5a, 8'ha5, 8'h3c, 1'b0);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        f = rand_flags();
        f.job_running = 1'b0;
        f.unloading_e = 1'b0;
        f.unloading_d = 1'b0;
        hold_level(1'b0, 4, f, 1'b0);
        hold_level(1'b1, 4, f, 1'b0);
        hold_level(1'b0, 100, f, 1'b0);
        hold_level(1'b1, 4, f, 1'b0);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    initial begin
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        out_if.ready = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_values();
        test_press_events();
        test_led_throb();
        test_config_extremes();
        test_random_sessions();
        test_backpressure();
        test_timer_saturation();
        drain_outputs();

        if (mismatch_count == 0) begin
            $display("** button_press_and_status_led_controller_top: PASSED **");
        end else begin
            $display("** button_press_and_status_led_controller_top: FAILED **");
        end
        $finish;
    end

endmodule
